// ----- sv/pse_pkg.sv -----
// ----------------------------------------------------------------------------
// pse_pkg
// Shared types, constants and helpers of the square-root envelope core.
// ----------------------------------------------------------------------------
package pse_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int DC_BITS     = SAMPLE_BITS + 8;
    localparam int LP_BITS     = SAMPLE_BITS + 24;
    localparam int LP_FRAC     = SAMPLE_BITS + 15;
    localparam int CMP_FRAC    = SAMPLE_BITS + 7;
    localparam int CMP_BITS    = SAMPLE_BITS + 8;
    localparam int S_BITS      = SAMPLE_BITS + 9;
    localparam int OP_BITS     = LP_BITS + 2;
    localparam int LO_W        = OP_BITS / 2;
    localparam int HI_W        = OP_BITS - LO_W;
    localparam int RAD_SH      = SAMPLE_BITS - 9;
    localparam int RAD_BITS    = 34;
    localparam int ROOT_BITS   = RAD_BITS / 2;
    localparam int CNT_BITS    = $clog2(CMP_BITS + 1);
    localparam int WIDE        = 68;

    localparam longint DC_POLE  = 65208;
    localparam longint ATTACK   = 5033165;
    localparam longint RELEASE  = 41943;
    localparam longint THRESH   = 12079596;
    localparam longint THR      = ((64'sd1 <<< CMP_FRAC) * THRESH + (64'sd1 <<< 23)) >>> 24;

    localparam logic [2:0] REG_LOWPASS = 3'd0;
    localparam logic [2:0] REG_GAIN    = 3'd1;
    localparam logic [2:0] REG_MOD     = 3'd2;
    localparam logic [2:0] REG_NORM    = 3'd3;
    localparam logic [2:0] REG_AMP     = 3'd4;

    typedef logic signed [WIDE-1:0] wide_t;

    typedef struct packed {
        logic [23:0] lowpass_coeff;
        logic [23:0] makeup_gain;
        logic [16:0] mod_depth;
        logic [16:0] envelope_norm;
        logic [16:0] out_scale;
    } cfg_t;

    typedef struct packed {
        logic                          valid;
        logic signed [SAMPLE_BITS-1:0] sample;
    } q_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DC,
        ST_L1_LO, ST_L1_HI, ST_L1_UPD,
        ST_L2_LO, ST_L2_HI, ST_L2_UPD,
        ST_G_LO, ST_G_HI, ST_G_UPD,
        ST_CMP, ST_DIV, ST_DFIN, ST_INNER, ST_SQRT, ST_NORM, ST_AMP
    } state_t;

    function automatic wide_t sat_signed(wide_t v, int bits);
        wide_t hi;
        wide_t lo;
        hi = (wide_t'(1) <<< (bits - 1)) - wide_t'(1);
        lo = -hi - wide_t'(1);
        if (v > hi)
            return hi;
        else if (v < lo)
            return lo;
        return v;
    endfunction

endpackage

// ----- sv/pse_front.sv -----
// ----------------------------------------------------------------------------
// pse_front
// Input side: takes sample transactions into a two-entry queue.
// ----------------------------------------------------------------------------
module pse_front (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic signed [pse_pkg::SAMPLE_BITS-1:0] sample_in,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    output pse_pkg::q_t                            head,
    input  logic                                   pop
);
    import pse_pkg::*;

    logic signed [SAMPLE_BITS-1:0] slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       do_pop;

    assign in_ready    = (count_reg != 2'd2);
    assign push        = in_valid && in_ready;
    assign do_pop      = pop && (count_reg != 2'd0);
    assign head.valid  = (count_reg != 2'd0);
    assign head.sample = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= sample_in;
    end

endmodule

// ----- sv/pse_back.sv -----
// ----------------------------------------------------------------------------
// pse_back
// Sequencer: filters, compressor, divider, square root and output register.
// ----------------------------------------------------------------------------
module pse_back (
    input  logic          clk,
    input  logic          rst_n,
    input  pse_pkg::q_t   head,
    output logic          pop,
    input  pse_pkg::cfg_t cfg,
    output logic [15:0]   envelope_out,
    output logic          out_valid,
    input  logic          out_ready
);
    import pse_pkg::*;

    state_t state_reg, state_next;

    logic signed [SAMPLE_BITS-1:0] dc_in_reg, dc_in_next;
    logic signed [DC_BITS-1:0]     dc_out_reg, dc_out_next;
    logic signed [LP_BITS-1:0]     lp1_reg, lp1_next;
    logic signed [LP_BITS-1:0]     lp2_reg, lp2_next;
    logic [CMP_BITS-1:0]           lvl_reg, lvl_next;
    logic [LO_W+23:0]              acc_reg, acc_next;
    wide_t                         rnd_reg, rnd_next;
    logic signed [S_BITS-1:0]      s_reg, s_next;
    logic [CMP_BITS-1:0]           mag_reg, mag_next;
    logic [CMP_BITS-1:0]           rem_reg, rem_next;
    logic [CMP_BITS-1:0]           numlo_reg, numlo_next;
    logic [CMP_BITS-1:0]           quo_reg, quo_next;
    logic [CNT_BITS-1:0]           cnt_reg, cnt_next;
    logic [RAD_BITS-1:0]           rad_reg, rad_next;
    logic [RAD_BITS:0]             root_reg, root_next;
    logic [RAD_BITS:0]             bit_reg, bit_next;
    logic [16:0]                   en_reg, en_next;
    logic [15:0]                   out_reg, out_next;
    logic                          out_valid_reg, out_valid_next;

    // shared wide multiplier, split into low and high partial products
    logic signed [OP_BITS-1:0]     op;
    logic [23:0]                   coef;
    logic signed [HI_W-1:0]        hi_part;
    logic signed [HI_W+24:0]       hi_prod;
    wide_t                         prod;
    wide_t                         tmp;
    wide_t                         env_w;
    logic signed [CMP_BITS:0]      diff;
    logic signed [CMP_BITS+25:0]   cprod;
    logic [2*CMP_BITS-1:0]         num;
    logic [CMP_BITS:0]             trial;
    logic [RAD_BITS:0]             sq_t;
    logic [33:0]                   nprod;

    assign envelope_out = out_reg;
    assign out_valid    = out_valid_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (head.valid && !out_valid_reg) state_next = ST_DC;
            ST_DC:     state_next = ST_L1_LO;
            ST_L1_LO:  state_next = ST_L1_HI;
            ST_L1_HI:  state_next = ST_L1_UPD;
            ST_L1_UPD: state_next = ST_L2_LO;
            ST_L2_LO:  state_next = ST_L2_HI;
            ST_L2_HI:  state_next = ST_L2_UPD;
            ST_L2_UPD: state_next = ST_G_LO;
            ST_G_LO:   state_next = ST_G_HI;
            ST_G_HI:   state_next = ST_G_UPD;
            ST_G_UPD:  state_next = ST_CMP;
            ST_CMP:    state_next = (wide_t'(lvl_next) > wide_t'(THR)) ? ST_DIV : ST_INNER;
            ST_DIV:    if (cnt_reg == CNT_BITS'(CMP_BITS - 1)) state_next = ST_DFIN;
            ST_DFIN:   state_next = ST_INNER;
            ST_INNER:  state_next = ST_SQRT;
            ST_SQRT:   if (bit_reg[0]) state_next = ST_NORM;
            ST_NORM:   state_next = ST_AMP;
            ST_AMP:    state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        dc_in_next     = dc_in_reg;
        dc_out_next    = dc_out_reg;
        lp1_next       = lp1_reg;
        lp2_next       = lp2_reg;
        lvl_next       = lvl_reg;
        acc_next       = acc_reg;
        rnd_next       = rnd_reg;
        s_next         = s_reg;
        mag_next       = mag_reg;
        rem_next       = rem_reg;
        numlo_next     = numlo_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        rad_next       = rad_reg;
        root_next      = root_reg;
        bit_next       = bit_reg;
        en_next        = en_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        pop            = 1'b0;
        tmp            = '0;
        env_w          = '0;
        diff           = '0;
        cprod          = '0;
        num            = '0;
        trial          = '0;
        sq_t           = '0;
        nprod          = '0;

        priority case (state_reg)
            ST_L1_LO, ST_L1_HI:
            begin
                op   = OP_BITS'(wide_t'(dc_out_reg) <<< 16) - OP_BITS'(lp1_reg);
                coef = cfg.lowpass_coeff;
            end
            ST_L2_LO, ST_L2_HI:
            begin
                op   = OP_BITS'(lp1_reg) - OP_BITS'(lp2_reg);
                coef = cfg.lowpass_coeff;
            end
            default:
            begin
                op   = OP_BITS'(lp2_reg);
                coef = cfg.makeup_gain;
            end
        endcase
        hi_part = op[OP_BITS-1:LO_W];
        hi_prod = hi_part * $signed({1'b0, coef});
        prod    = (wide_t'(hi_prod) <<< LO_W) + wide_t'(acc_reg);

        unique case (state_reg)
            ST_IDLE: ;
            ST_DC:
            begin
                pop = 1'b1;
                tmp = wide_t'(dc_out_reg) * wide_t'(DC_POLE);
                tmp = (tmp + wide_t'(32768)) >>> 16;
                tmp = wide_t'(head.sample) - wide_t'(dc_in_reg) + tmp;
                dc_out_next = DC_BITS'(sat_signed(tmp, DC_BITS));
                dc_in_next  = head.sample;
            end
            ST_L1_LO, ST_L2_LO, ST_G_LO:
                acc_next = {24'd0, op[LO_W-1:0]} * {{LO_W{1'b0}}, coef};
            ST_L1_HI, ST_L2_HI:
                rnd_next = (prod + (wide_t'(1) <<< 23)) >>> 24;
            ST_G_HI:
                rnd_next = (prod + wide_t'(128)) >>> 8;
            ST_L1_UPD:
                lp1_next = LP_BITS'(sat_signed(wide_t'(lp1_reg) + rnd_reg, LP_BITS));
            ST_L2_UPD:
                lp2_next = LP_BITS'(sat_signed(wide_t'(lp2_reg) + rnd_reg, LP_BITS));
            ST_G_UPD:
            begin
                tmp = rnd_reg;
                if (tmp > (wide_t'(1) <<< LP_FRAC))
                    tmp = wide_t'(1) <<< LP_FRAC;
                if (tmp < -(wide_t'(1) <<< LP_FRAC))
                    tmp = -(wide_t'(1) <<< LP_FRAC);
                s_next = S_BITS'((tmp + wide_t'(128)) >>> 8);
            end
            ST_CMP:
            begin
                mag_next = s_reg[S_BITS-1] ? CMP_BITS'(-s_reg) : CMP_BITS'(s_reg);
                diff     = $signed({1'b0, mag_next}) - $signed({1'b0, lvl_reg});
                cprod    = diff * $signed((mag_next > lvl_reg) ? 25'(ATTACK) : 25'(RELEASE));
                env_w    = wide_t'(lvl_reg) + ((wide_t'(cprod) + (wide_t'(1) <<< 23)) >>> 24);
                if (env_w < 0)
                    env_w = '0;
                if (env_w > ((wide_t'(1) <<< CMP_BITS) - wide_t'(1)))
                    env_w = (wide_t'(1) <<< CMP_BITS) - wide_t'(1);
                lvl_next   = CMP_BITS'(env_w);
                num        = (2*CMP_BITS)'(mag_next) * (2*CMP_BITS)'(THR)
                           + (2*CMP_BITS)'(lvl_next >> 1);
                rem_next   = num[2*CMP_BITS-1:CMP_BITS];
                numlo_next = num[CMP_BITS-1:0];
                quo_next   = '0;
                cnt_next   = '0;
            end
            ST_DIV:
            begin
                trial = {rem_reg, numlo_reg[CMP_BITS-1]};
                if (trial >= {1'b0, lvl_reg})
                begin
                    trial    = trial - {1'b0, lvl_reg};
                    quo_next = {quo_reg[CMP_BITS-2:0], 1'b1};
                end
                else
                    quo_next = {quo_reg[CMP_BITS-2:0], 1'b0};
                rem_next   = trial[CMP_BITS-1:0];
                numlo_next = {numlo_reg[CMP_BITS-2:0], 1'b0};
                cnt_next   = cnt_reg + CNT_BITS'(1);
            end
            ST_DFIN:
                s_next = s_reg[S_BITS-1] ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
            ST_INNER:
            begin
                tmp = (wide_t'(1) <<< (CMP_FRAC + 16))
                    + wide_t'(cfg.mod_depth) * wide_t'(s_reg);
                if (tmp < 0)
                    tmp = '0;
                rad_next  = RAD_BITS'((tmp + (wide_t'(1) <<< (RAD_SH - 1))) >>> RAD_SH);
                root_next = '0;
                bit_next  = (RAD_BITS+1)'(1) << (RAD_BITS - 2);
            end
            ST_SQRT:
            begin
                sq_t = root_reg + bit_reg;
                if ({1'b0, rad_reg} >= sq_t)
                begin
                    rad_next  = RAD_BITS'({1'b0, rad_reg} - sq_t);
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                    root_next = root_reg >> 1;
                bit_next = bit_reg >> 2;
            end
            ST_NORM:
            begin
                nprod = 34'(root_reg[ROOT_BITS-1:0]) * 34'(cfg.envelope_norm) + 34'd32768;
                en_next = (nprod[33:16] > 18'd65536) ? 17'd65536 : nprod[32:16];
            end
            ST_AMP:
            begin
                nprod = 34'(en_reg) * 34'(cfg.out_scale) + 34'd32768;
                out_next       = (nprod[33:16] > 18'd65535) ? 16'hFFFF : nprod[31:16];
                out_valid_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dc_in_reg     <= '0;
            dc_out_reg    <= '0;
            lp1_reg       <= '0;
            lp2_reg       <= '0;
            lvl_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dc_in_reg     <= dc_in_next;
            dc_out_reg    <= dc_out_next;
            lp1_reg       <= lp1_next;
            lp2_reg       <= lp2_next;
            lvl_reg       <= lvl_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        rnd_reg   <= rnd_next;
        s_reg     <= s_next;
        mag_reg   <= mag_next;
        rem_reg   <= rem_next;
        numlo_reg <= numlo_next;
        quo_reg   <= quo_next;
        cnt_reg   <= cnt_next;
        rad_reg   <= rad_next;
        root_reg  <= root_next;
        bit_reg   <= bit_next;
        en_reg    <= en_next;
        out_reg   <= out_next;
    end

endmodule

// ----- sv/parametric_sqrt_envelope_core.sv -----
// ----------------------------------------------------------------------------
// parametric_sqrt_envelope_core
// Audio sample in, square-root AM carrier envelope out; APB register file.
// ----------------------------------------------------------------------------
// The sequencer handles one transaction at a time, through a restoring divider
// (only when the compressor divides) and a bit-serial square root; it starts the
// next only once the previous output has been taken.
// A two-entry input queue keeps accepting while the sequencer is busy, until full.
// Reset (async, active low) clears filter and compressor state, the queue
// and the output valid, and loads the register defaults.
module parametric_sqrt_envelope_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [4:0]                             paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready,
    input  logic signed [pse_pkg::SAMPLE_BITS-1:0] sample_in,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    output logic [15:0]                            envelope_out,
    output logic                                   out_valid,
    input  logic                                   out_ready
);
    import pse_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    q_t         head;
    logic       pop;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[4:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_LOWPASS: cfg_next.lowpass_coeff = pwdata[23:0];
                REG_GAIN:    cfg_next.makeup_gain   = pwdata[23:0];
                REG_MOD:     cfg_next.mod_depth     = pwdata[16:0];
                REG_NORM:    cfg_next.envelope_norm = pwdata[16:0];
                REG_AMP:     cfg_next.out_scale     = pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_LOWPASS: prdata = 32'(cfg_reg.lowpass_coeff);
            REG_GAIN:    prdata = 32'(cfg_reg.makeup_gain);
            REG_MOD:     prdata = 32'(cfg_reg.mod_depth);
            REG_NORM:    prdata = 32'(cfg_reg.envelope_norm);
            REG_AMP:     prdata = 32'(cfg_reg.out_scale);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lowpass_coeff <= 24'd54904;
            cfg_reg.makeup_gain   <= 24'd92160;
            cfg_reg.mod_depth     <= 17'd55706;
            cfg_reg.envelope_norm <= 17'd48183;
            cfg_reg.out_scale     <= 17'd65536;
        end
        else
            cfg_reg <= cfg_next;
    end

    pse_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_in (sample_in),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .head      (head),
        .pop       (pop)
    );

    pse_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .cfg          (cfg_reg),
        .envelope_out (envelope_out),
        .out_valid    (out_valid),
        .out_ready    (out_ready)
    );

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square-root envelope core testbench
// Streams audio samples through the core under random idle on both sides,
// predicts each envelope from its own filter/compressor model, and walks
// the register file through defaults, extremes and random settings.
// ----------------------------------------------------------------------------
class envelope_scoreboard;
    longint unsigned coeff, gain, mod_idx, norm, amp;
    longint dc_in, dc_out, lp1, lp2, level;
    logic [15:0] pending[$];
    int mismatches;

    function new();
        coeff = 54904; gain = 92160; mod_idx = 55706; norm = 48183; amp = 65536;
        dc_in = 0; dc_out = 0; lp1 = 0; lp2 = 0; level = 0;
        mismatches = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
        case (idx)
            pse_pkg::REG_LOWPASS: coeff   = val[23:0];
            pse_pkg::REG_GAIN:    gain    = val[23:0];
            pse_pkg::REG_MOD:     mod_idx = val[16:0];
            pse_pkg::REG_NORM:    norm    = val[16:0];
            pse_pkg::REG_AMP:     amp     = val[16:0];
            default: ;
        endcase
    endfunction

    // round(v*c/2^n) halves up, split to avoid overflow
    function longint mulr(longint v, longint unsigned c, int n);
        longint hi;
        longint unsigned lo, part;
        hi = v >>> n;
        lo = longint'(v) - (hi <<< n);
        part = (lo * c + (64'd1 << (n - 1))) >> n;
        return hi * longint'(c) + longint'(part);
    endfunction

    function longint sat(longint v, int bits);
        longint hi;
        hi = (64'sd1 <<< (bits - 1)) - 1;
        return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
    endfunction

    function longint unsigned root_floor(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function void note_sample(logic signed [15:0] smp);
        longint x, y, p, s, mag, env, thr, inner;
        longint unsigned coefc, q, e, en, o;
        longint one_lp;
        x = smp;
        y = sat(x - dc_in + mulr(dc_out, 65208, 16), 24);
        dc_in = x;
        dc_out = y;
        lp1 = sat(lp1 + mulr(y * 65536 - lp1, coeff, 24), 40);
        lp2 = sat(lp2 + mulr(lp1 - lp2, coeff, 24), 40);
        one_lp = 64'sd1 <<< 31;
        p = mulr(lp2, gain, 8);
        if (p > one_lp) p = one_lp;
        if (p < -one_lp) p = -one_lp;
        s = (p + 128) >>> 8;
        mag = s < 0 ? -s : s;
        env = level;
        coefc = mag > env ? 5033165 : 41943;
        env += mulr(mag - env, coefc, 24);
        if (env < 0) env = 0;
        if (env > (64'sd1 <<< 24) - 1) env = (64'sd1 <<< 24) - 1;
        level = env;
        thr = mulr(64'sd1 <<< 23, 12079596, 24);
        if (env > thr) begin
            q = (longint'(mag) * thr + (env >> 1)) / env;
            s = s < 0 ? -longint'(q) : longint'(q);
        end
        inner = (64'sd1 <<< 39) + longint'(mod_idx) * s;
        if (inner < 0) inner = 0;
        e = root_floor((inner + 64) >>> 7);
        en = (e * norm + 32768) >> 16;
        if (en > 65536) en = 65536;
        o = (en * amp + 32768) >> 16;
        if (o > 65535) o = 65535;
        pending.push_back(o[15:0]);
    endfunction

    function void check_envelope(logic [15:0] got);
        logic [15:0] want;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected envelope %0d", got);
            return;
        end
        want = pending.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("envelope_out: expected %0d, got %0d", want, got);
        end
    endfunction
endclass

module testbench;
    import pse_pkg::*;

    logic clk = 0;
    logic rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [4:0] paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic pready;
    logic signed [15:0] sample_in = 0;
    logic in_valid = 0;
    logic in_ready;
    logic [15:0] envelope_out;
    logic out_valid;
    logic out_ready = 0;
    logic calm = 0;
    int quiet_cycles = 0;
    envelope_scoreboard sb = new();

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    parametric_sqrt_envelope_core dut (.*);

    always @(posedge clk) begin
        if (out_valid && out_ready) sb.check_envelope(envelope_out);
        out_ready <= calm || $urandom_range(99) >= 13;
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (rst_n && !psel)
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge clk);
        psel <= 1; pwrite <= 1; penable <= 0; paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.set_reg(idx, val);
    endtask

    // in_valid stays high across back-to-back transactions; idle drops it
    task automatic send_sample(logic signed [15:0] smp);
        while (!calm && $urandom_range(99) < 13) begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        sample_in <= smp;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_sample(smp);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic random_samples(int n);
        int k;
        logic signed [15:0] v;
        for (k = 0; k < n; k++) begin
            case ($urandom_range(3))
                0: v = 16'($urandom);
                1: v = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
                2: v = 16'($signed($urandom_range(2000)) - 1000);
                default: v = (k % 40 < 20) ? 16'sh6000 : -16'sh6000;
            endcase
            send_sample(v);
        end
    endtask

    initial begin
        int ph, k;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        // directed: extremes, zero, steps driving the compressor hard
        send_sample(16'sh0000);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample(16'sh0001);
        send_sample(16'shffff);
        for (k = 0; k < 10; k++) send_sample(16'sh7fff);
        for (k = 0; k < 8; k++) send_sample(16'sh8000);
        drain();
        // extremes: coefficient at 0.5 and at maximum, zero and full gain, zero norm
        write_reg(REG_LOWPASS, 32'd8388608);
        write_reg(REG_GAIN, 32'd16777215);
        write_reg(REG_MOD, 32'd65536);
        write_reg(REG_NORM, 32'd0);
        write_reg(REG_AMP, 32'd0);
        random_samples(40);
        drain();
        write_reg(REG_LOWPASS, 32'hffffff);
        write_reg(REG_GAIN, 32'd0);
        write_reg(REG_NORM, 32'd65536);
        write_reg(REG_AMP, 32'd65536);
        random_samples(40);
        drain();
        write_reg(REG_LOWPASS, 32'd8388608);
        write_reg(REG_GAIN, 32'd256);
        write_reg(REG_MOD, 32'd0);
        random_samples(40);
        drain();
        for (ph = 0; ph < 8; ph++) begin
            calm = (ph == 3);
            write_reg(REG_LOWPASS, $urandom_range(8388608));
            write_reg(REG_GAIN, $urandom_range(ph[0] ? 16777215 : 4000));
            write_reg(REG_MOD, $urandom_range(65536));
            write_reg(REG_NORM, $urandom_range(65536));
            write_reg(REG_AMP, $urandom_range(65536));
            random_samples(160);
            drain();
        end
        calm = 0;
        write_reg(REG_LOWPASS, 32'd54904);
        write_reg(REG_GAIN, 32'd92160);
        write_reg(REG_MOD, 32'd55706);
        write_reg(REG_NORM, 32'd48183);
        write_reg(REG_AMP, 32'd65536);
        random_samples(100);
        drain();
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
